// ===== src/enms_pkg.sv =====
// Shared types and constants for the edge non-maximum suppression core.
// No dependencies; every other file in src refers to it by scoped names.
package enms_pkg;

    localparam int MAG_W      = 16;
    localparam int ANG_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int WIN_REGS   = 6;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [MAG_W-1:0]      t_mag;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [1:0]            t_dir;
    typedef logic [1:0]            t_kind;

    // Register indexes of the configuration port.
    localparam t_cfg_addr CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_addr CFG_IMAGE_HEIGHT = 2'd1;
    localparam t_cfg_addr CFG_MIN_MAG      = 2'd2;

    // Quantized gradient directions.
    localparam t_dir DIR_DIAG = 2'd0; // up-left / down-right
    localparam t_dir DIR_VERT = 2'd1; // up / down
    localparam t_dir DIR_ANTI = 2'd2; // up-right / down-left
    localparam t_dir DIR_HORZ = 2'd3; // left / right

    // Kinds of result that one pixel can cause.
    localparam t_kind KIND_CENTER = 2'd0; // window center of the previous row
    localparam t_kind KIND_RIGHT  = 2'd1; // right border of the previous row
    localparam t_kind KIND_PASS   = 2'd2; // top or bottom row pass-through

    // One entry of the line memory: the two stored rows and the direction.
    typedef struct packed {
        t_mag older;
        t_mag newer;
        t_dir dir;
    } t_line_word;

    // Which results a pixel causes, worked out when it is taken in.
    typedef struct packed {
        logic has_center;
        logic has_right;
        logic has_pass;
        logic col_ge2;
    } t_res_flags;

    // direction = (((angle >> 12) + 15) mod 8) / 2
    function automatic t_dir quant_dir(input logic [ANG_W-1:0] angle);
        logic [2:0] sector;
        sector = angle[14:12] + 3'd7;
        return sector[2:1];
    endfunction

endpackage

// ===== src/enms_line_mem.sv =====
// Line memory: two stored magnitude rows and the direction row, one word a column.
// Depends on enms_pkg for the word layout.
module enms_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output enms_pkg::t_line_word o_rd_data,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  enms_pkg::t_line_word i_wr_data
);

    enms_pkg::t_line_word r_mem [DEPTH];
    enms_pkg::t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/enms_window.sv =====
// 3x3 window registers and the suppression decision for the window center.
// Depends on enms_pkg for magnitude and direction types.
module enms_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  enms_pkg::t_mag i_top,
    input  enms_pkg::t_mag i_mid,
    input  enms_pkg::t_mag i_mag,
    input  enms_pkg::t_dir i_old_dir,
    input  logic           i_col_ge2,
    input  enms_pkg::t_mag i_min_mag,
    output enms_pkg::t_mag o_value_center
);

    // [0..2] center column top to bottom, [3..5] left column.
    enms_pkg::t_mag r_win [enms_pkg::WIN_REGS];
    enms_pkg::t_dir r_ctr_dir;

    enms_pkg::t_mag ctr, g1, g2;

    always_comb begin
        ctr = r_win[1];
        case (r_ctr_dir)
            enms_pkg::DIR_DIAG: begin
                g1 = r_win[3];
                g2 = i_mag;
            end
            enms_pkg::DIR_VERT: begin
                g1 = r_win[0];
                g2 = r_win[2];
            end
            enms_pkg::DIR_ANTI: begin
                g1 = i_top;
                g2 = r_win[5];
            end
            default: begin
                g1 = r_win[4];
                g2 = i_mid;
            end
        endcase
        // Drop weak or non-peak centers; column 1 reports the left border as zero.
        if (!i_col_ge2 || ctr < i_min_mag || g1 > ctr || g2 > ctr) begin
            o_value_center = '0;
        end else begin
            o_value_center = ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < enms_pkg::WIN_REGS; i++) begin
                r_win[i] <= '0;
            end
            r_ctr_dir <= enms_pkg::DIR_DIAG;
        end else if (i_shift) begin
            r_win[3]  <= r_win[0];
            r_win[4]  <= r_win[1];
            r_win[5]  <= r_win[2];
            r_win[0]  <= i_top;
            r_win[1]  <= i_mid;
            r_win[2]  <= i_mag;
            r_ctr_dir <= i_old_dir;
        end
    end

endmodule

// ===== src/enms_out_queue.sv =====
// Result queue: one entry per pixel, unloaded one result per transfer.
// Depends on enms_pkg for flags, result kinds and queue depth.
module enms_out_queue #(
    parameter int ROW_W = 12,
    parameter int COL_W = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [COL_W-1:0]        i_col,
    input  enms_pkg::t_mag          i_value_center,
    input  enms_pkg::t_mag          i_mag,
    input  enms_pkg::t_res_flags    i_flags,
    input  logic                    i_inflight,
    output logic                    o_room,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ROW_W-1:0]        o_row,
    output logic [COL_W-1:0]        o_col,
    output enms_pkg::t_mag          o_value,
    output logic                    o_last
);

    localparam int D  = enms_pkg::QUEUE_DEPTH;
    localparam int PW = enms_pkg::QUEUE_PTR_W;
    localparam int CW = enms_pkg::QUEUE_CNT_W;

    logic [ROW_W-1:0]     r_row   [D];
    logic [COL_W-1:0]     r_col   [D];
    enms_pkg::t_mag       r_vctr  [D];
    enms_pkg::t_mag       r_mag   [D];
    enms_pkg::t_res_flags r_flags [D];

    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_sub, n_sub;

    enms_pkg::t_res_flags h_flags;
    enms_pkg::t_kind      kind;
    logic [1:0]           n_res;
    logic                 xfer, pop;

    assign h_flags = r_flags[r_rd_ptr];
    assign n_res   = 2'(h_flags.has_center) + 2'(h_flags.has_right) + 2'(h_flags.has_pass);
    assign o_valid = (r_count != '0);
    assign o_last  = (r_sub == n_res - 2'd1);
    assign xfer    = o_valid && i_ready;
    assign pop     = xfer && o_last;
    assign o_room  = ((CW+1)'(r_count) + (CW+1)'(i_inflight)) < (CW+1)'(D);

    // Order within one pixel: center, right border, pass-through.
    always_comb begin
        case (r_sub)
            2'd0:    kind = h_flags.has_center ? enms_pkg::KIND_CENTER : enms_pkg::KIND_PASS;
            2'd1:    kind = h_flags.has_right ? enms_pkg::KIND_RIGHT : enms_pkg::KIND_PASS;
            default: kind = enms_pkg::KIND_PASS;
        endcase
    end

    always_comb begin
        case (kind)
            enms_pkg::KIND_CENTER: begin
                o_row   = r_row[r_rd_ptr] - ROW_W'(1);
                o_col   = r_col[r_rd_ptr] - COL_W'(1);
                o_value = r_vctr[r_rd_ptr];
            end
            enms_pkg::KIND_RIGHT: begin
                o_row   = r_row[r_rd_ptr] - ROW_W'(1);
                o_col   = r_col[r_rd_ptr];
                o_value = '0;
            end
            default: begin
                o_row   = r_row[r_rd_ptr];
                o_col   = r_col[r_rd_ptr];
                o_value = r_mag[r_rd_ptr];
            end
        endcase
    end

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count + CW'(i_push) - CW'(pop);
        if (pop) begin
            n_sub = 2'd0;
        end else if (xfer) begin
            n_sub = r_sub + 2'd1;
        end else begin
            n_sub = r_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_row[r_wr_ptr]   <= i_row;
            r_col[r_wr_ptr]   <= i_col;
            r_vctr[r_wr_ptr]  <= i_value_center;
            r_mag[r_wr_ptr]   <= i_mag;
            r_flags[r_wr_ptr] <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_sub    <= n_sub;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(D)) || pop)
        else $error("result queue overflow");

    a_no_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (n_res != 2'd0) && (r_sub < n_res))
        else $error("queue head holds no result at the current position");

    a_sub_clears_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_sub == 2'd0))
        else $error("result position not cleared after a pixel was unloaded");

endmodule

// ===== src/edge_nonmax_suppression_core.sv =====
// Edge non-maximum suppression core: top level.
// Depends on enms_pkg, enms_line_mem, enms_window and enms_out_queue.
//
// Takes a raster stream of gradient magnitude (unsigned Q12.4) and angle (a 16-bit
// fraction of a full turn) and gives one result per pixel: interior pixels keep their
// magnitude only when it reaches min_magnitude and neither neighbor along the quantized
// gradient direction is greater; the left and right columns give zero; the top and bottom
// rows pass through. Results carry row and column and leave as soon as their 3x3 window
// is complete, so a pixel causes zero to three results. A pixel can be accepted every
// clock while the queue has room: one transfer in, and via stage 1 its results reach a
// four-entry queue that unloads one result per output transfer. The line memory (one
// read and one write per cycle) sets the one-pixel-per-clock input rate; over a frame the
// output needs about one transfer per pixel, with an extra one at each row end and the
// bottom row needing two, so the input is held off when the output side falls behind. The
// line memory has no reset and needs no clearing pass: the first two rows of every frame
// fill it before any window reads it. Writing image_width or image_height restarts the
// frame at row 0, column 0; width uses bits [10:0], height [12:0], and sizes outside [3,
// MAX_WIDTH] and [3, MAX_HEIGHT] saturate. Configure only while no pixel is in flight.
module edge_nonmax_suppression_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [enms_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [enms_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [enms_pkg::MAG_W-1:0]      i_magnitude,
    input  logic [enms_pkg::ANG_W-1:0]      i_angle,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ROW_W-1:0]                o_out_row,
    output logic [COL_W-1:0]                o_out_col,
    output logic [enms_pkg::MAG_W-1:0]      o_out_value,
    output logic                            o_last
);

    // Reset geometry, saturated to the configured maximum.
    localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    // Stored as size minus one so the last column and row compare directly.
    logic [COL_W-1:0]     r_w_last, n_w_last;
    logic [ROW_W-1:0]     r_h_last, n_h_last;
    enms_pkg::t_mag       r_min_mag;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;

    // Stage 1: pixel waiting on its line memory read.
    logic                 r_s1_valid;
    enms_pkg::t_mag       r_s1_mag;
    enms_pkg::t_dir       r_s1_dir;
    logic [COL_W-1:0]     r_s1_col;
    logic [ROW_W-1:0]     r_s1_row;
    enms_pkg::t_res_flags r_s1_flags;

    logic                 accept;
    logic                 geom_write;
    logic                 row_ge2;
    logic [13:0]          cfg_w;
    logic [14:0]          cfg_h;
    enms_pkg::t_res_flags flags;
    enms_pkg::t_line_word rd_word, wr_word;
    enms_pkg::t_mag       value_center;
    logic                 push;

    assign accept     = i_in_valid && o_in_ready;
    assign geom_write = i_cfg_we && (i_cfg_addr == enms_pkg::CFG_IMAGE_WIDTH
                                  || i_cfg_addr == enms_pkg::CFG_IMAGE_HEIGHT);

    // Saturate the geometry on write.
    always_comb begin
        cfg_w = {3'b000, i_cfg_wdata[10:0]};
        cfg_h = {2'b00, i_cfg_wdata[12:0]};
        if (cfg_w < 14'd3) begin
            n_w_last = COL_W'(2);
        end else if (cfg_w > 14'(MAX_WIDTH)) begin
            n_w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_w_last = COL_W'(cfg_w - 14'd1);
        end
        if (cfg_h < 15'd3) begin
            n_h_last = ROW_W'(2);
        end else if (cfg_h > 15'(MAX_HEIGHT)) begin
            n_h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_h_last = ROW_W'(cfg_h - 15'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last  <= COL_W'(RST_W - 1);
            r_h_last  <= ROW_W'(RST_H - 1);
            r_min_mag <= 16'd800;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                enms_pkg::CFG_IMAGE_WIDTH:  r_w_last  <= n_w_last;
                enms_pkg::CFG_IMAGE_HEIGHT: r_h_last  <= n_h_last;
                enms_pkg::CFG_MIN_MAG:      r_min_mag <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Raster position of the next pixel; advance on each input transfer.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (r_col == r_w_last) begin
                n_col = '0;
                n_row = (r_row == r_h_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_write) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Work out which results this pixel causes while its memory read is out.
    always_comb begin
        row_ge2          = (r_row[ROW_W-1:1] != '0);
        flags.has_center = row_ge2 && (r_col != '0);
        flags.has_right  = row_ge2 && (r_col == r_w_last);
        flags.has_pass   = (r_row == '0) || (r_row == r_h_last);
        flags.col_ge2    = (r_col[COL_W-1:1] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mag   <= i_magnitude;
            r_s1_dir   <= enms_pkg::quant_dir(i_angle);
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_flags <= flags;
        end
    end

    // Shift the rows down one line in the same column: rows r-2, r-1 become r-1, r.
    assign wr_word.older = rd_word.newer;
    assign wr_word.newer = r_s1_mag;
    assign wr_word.dir   = r_s1_dir;

    enms_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_word),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_word)
    );

    enms_window u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_shift        (r_s1_valid),
        .i_top          (rd_word.older),
        .i_mid          (rd_word.newer),
        .i_mag          (r_s1_mag),
        .i_old_dir      (rd_word.dir),
        .i_col_ge2      (r_s1_flags.col_ge2),
        .i_min_mag      (r_min_mag),
        .o_value_center (value_center)
    );

    // Second-row pixels, and column 0 of rows 2 to height-2, cause nothing; skip them.
    assign push = r_s1_valid && (r_s1_flags.has_center || r_s1_flags.has_right
                              || r_s1_flags.has_pass);

    enms_out_queue #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_out_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_row          (r_s1_row),
        .i_col          (r_s1_col),
        .i_value_center (value_center),
        .i_mag          (r_s1_mag),
        .i_flags        (r_s1_flags),
        .i_inflight     (r_s1_valid),
        .o_room         (o_in_ready),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_row          (o_out_row),
        .o_col          (o_out_col),
        .o_value        (o_out_value),
        .o_last         (o_last)
    );

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_w_last) && (r_row <= r_h_last))
        else $error("raster position outside the frame");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_s1_valid) |-> (r_col != r_s1_col))
        else $error("line memory read and write hit the same column");

    a_stage1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid && (r_s1_col == $past(r_col)))
        else $error("accepted pixel did not reach stage 1");

endmodule
